// ===== rtl/u8sd_pkg.sv =====
package u8sd_pkg;

  localparam int COUNT_WIDTH = 32;
  localparam int CP_WIDTH    = 31;

  localparam logic KIND_CODE_POINT = 1'b0;
  localparam logic KIND_SUMMARY    = 1'b1;

  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_INVALID = 1'b1;

  localparam logic [7:0] BOM_BYTE0 = 8'hEF;
  localparam logic [7:0] BOM_BYTE1 = 8'hBB;
  localparam logic [7:0] BOM_BYTE2 = 8'hBF;

  localparam logic [CP_WIDTH-1:0] SCALAR_LIMIT   = 31'h0011_0000;
  localparam logic [CP_WIDTH-1:0] SURROGATE_LOW  = 31'h0000_D800;
  localparam logic [CP_WIDTH-1:0] SURROGATE_HIGH = 31'h0000_DFFF;

  typedef struct packed {
    logic       valid;
    logic [7:0] data_byte;
    logic       is_terminator;
  } item_t;

  typedef struct packed {
    logic                valid;
    logic                kind;
    logic [CP_WIDTH-1:0] code_point;
    logic                scalar_ok;
    logic [31:0]         char_count;
    logic                status;
  } result_t;

  typedef struct packed {
    logic [2:0] len;
    logic [6:0] payload;
  } lead_t;

  function automatic lead_t classify_lead(input logic [7:0] b);
    lead_t r;
    r = '0;
    if (b[7] == 1'b0) begin
      r.len = 3'd1;
      r.payload = b[6:0];
    end else if (b[7:5] == 3'b110) begin
      r.len = 3'd2;
      r.payload = {2'b00, b[4:0]};
    end else if (b[7:4] == 4'b1110) begin
      r.len = 3'd3;
      r.payload = {3'b000, b[3:0]};
    end else if (b[7:3] == 5'b11110) begin
      r.len = 3'd4;
      r.payload = {4'b0000, b[2:0]};
    end else if (b[7:2] == 6'b111110) begin
      r.len = 3'd5;
      r.payload = {5'b00000, b[1:0]};
    end else if (b[7:1] == 7'b1111110) begin
      r.len = 3'd6;
      r.payload = {6'b000000, b[0]};
    end
    return r;
  endfunction

  function automatic logic [7:0] bom_byte(input logic [1:0] pos);
    logic [7:0] r;
    case (pos)
      2'd0:    r = BOM_BYTE0;
      2'd1:    r = BOM_BYTE1;
      2'd2:    r = BOM_BYTE2;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic is_scalar(input logic [CP_WIDTH-1:0] cp);
    return (cp < SCALAR_LIMIT) && ((cp < SURROGATE_LOW) || (cp > SURROGATE_HIGH));
  endfunction

  function automatic logic [31:0] reported_count(input logic [COUNT_WIDTH-1:0] cnt);
    logic [63:0] ext;
    ext = 64'(cnt);
    return (|ext[63:32]) ? 32'hFFFF_FFFF : ext[31:0];
  endfunction

endpackage

// ===== rtl/utf8_stream_decoder.sv =====
// Channel   Direction  Handshake           Word
// in_       input      in_valid/in_stall   data_byte, is_terminator
// out_      output     out_valid/out_stall kind, code_point, scalar_ok, char_count, status
// cfg_      input      cfg_valid/cfg_ready skip_bom on cfg_data
//
// One byte can be accepted every cycle while the out_ side does not stall; its result
// passes from the input register into the result register, which drives the out_ ports.
// Reset (rst_n low, synchronous) empties both registers, clears the stream state
// and sets skip_bom to 1.
// A stalled result register holds its word and stalls the input only once the
// input register is full; cfg_ready is always high.
module utf8_stream_decoder (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [7:0]                    in_data_byte,
  input  logic                          in_is_terminator,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_kind,
  output logic [u8sd_pkg::CP_WIDTH-1:0] out_code_point,
  output logic                          out_scalar_ok,
  output logic [31:0]                   out_char_count,
  output logic                          out_status,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic                          cfg_data
);

  logic              skip_bom_r;
  logic              advance;
  u8sd_pkg::item_t   item;
  u8sd_pkg::result_t result;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skip_bom_r <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      skip_bom_r <= cfg_data;
    end
  end

  u8sd_in_stage u_in_stage (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_data_byte     (in_data_byte),
    .in_is_terminator (in_is_terminator),
    .advance          (advance),
    .item             (item)
  );

  u8sd_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .skip_bom (skip_bom_r),
    .item     (item),
    .advance  (advance),
    .result   (result)
  );

  u8sd_out_stage u_out_stage (
    .clk            (clk),
    .rst_n          (rst_n),
    .item_valid     (item.valid),
    .result         (result),
    .advance        (advance),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_kind       (out_kind),
    .out_code_point (out_code_point),
    .out_scalar_ok  (out_scalar_ok),
    .out_char_count (out_char_count),
    .out_status     (out_status)
  );

endmodule

// ===== rtl/u8sd_in_stage.sv =====
module u8sd_in_stage (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [7:0]      in_data_byte,
  input  logic            in_is_terminator,
  input  logic            advance,
  output u8sd_pkg::item_t item
);

  logic       valid_r, valid_nxt;
  logic [7:0] byte_r;
  logic       term_r;
  logic       accept;

  assign in_stall = valid_r && !advance;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      byte_r <= in_data_byte;
      term_r <= in_is_terminator;
    end
  end

  assign item.valid         = valid_r;
  assign item.data_byte     = byte_r;
  assign item.is_terminator = term_r;

endmodule

// ===== rtl/u8sd_core.sv =====
module u8sd_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              skip_bom,
  input  u8sd_pkg::item_t   item,
  input  logic              advance,
  output u8sd_pkg::result_t result
);

  logic [u8sd_pkg::CP_WIDTH-1:0]    acc_r, acc_nxt;
  logic [2:0]                       rem_r, rem_nxt;
  logic [u8sd_pkg::COUNT_WIDTH-1:0] count_r, count_nxt;
  logic                             err_r, err_nxt;
  logic [1:0]                       bom_pos_r, bom_pos_nxt;
  logic                             bom_cand_r, bom_cand_nxt;

  u8sd_pkg::lead_t               lead;
  logic                          mark_done;
  logic                          done;
  logic [u8sd_pkg::CP_WIDTH-1:0] cp;
  logic [u8sd_pkg::CP_WIDTH-1:0] shifted;

  always_comb begin
    acc_nxt      = acc_r;
    rem_nxt      = rem_r;
    count_nxt    = count_r;
    err_nxt      = err_r;
    bom_pos_nxt  = bom_pos_r;
    bom_cand_nxt = bom_cand_r;
    mark_done    = 1'b0;
    done         = 1'b0;
    cp           = '0;
    lead         = u8sd_pkg::classify_lead(item.data_byte);
    shifted      = {acc_r[u8sd_pkg::CP_WIDTH-7:0], item.data_byte[5:0]};
    result       = '0;
    result.kind  = u8sd_pkg::KIND_CODE_POINT;

    if (item.is_terminator) begin
      result.valid      = 1'b1;
      result.kind       = u8sd_pkg::KIND_SUMMARY;
      result.char_count = u8sd_pkg::reported_count(count_r);
      result.status     = (err_r || rem_r != 3'd0) ? u8sd_pkg::STATUS_INVALID
                                                   : u8sd_pkg::STATUS_OK;
      acc_nxt      = '0;
      rem_nxt      = 3'd0;
      count_nxt    = '0;
      err_nxt      = 1'b0;
      bom_pos_nxt  = 2'd0;
      bom_cand_nxt = 1'b1;
    end else if (!err_r) begin
      if (bom_cand_r) begin
        if (bom_pos_r != 2'd3 && item.data_byte == u8sd_pkg::bom_byte(bom_pos_r)) begin
          bom_pos_nxt = bom_pos_r + 2'd1;
          if (bom_pos_r == 2'd2) begin
            mark_done    = 1'b1;
            bom_cand_nxt = 1'b0;
          end
        end else begin
          bom_cand_nxt = 1'b0;
        end
      end

      if (rem_r == 3'd0) begin
        if (lead.len == 3'd0) begin
          err_nxt = 1'b1;
        end else if (lead.len == 3'd1) begin
          cp   = u8sd_pkg::CP_WIDTH'(lead.payload);
          done = 1'b1;
        end else begin
          acc_nxt = u8sd_pkg::CP_WIDTH'(lead.payload);
          rem_nxt = lead.len - 3'd1;
        end
      end else begin
        acc_nxt = shifted;
        rem_nxt = rem_r - 3'd1;
        if (rem_r == 3'd1) begin
          cp   = shifted;
          done = 1'b1;
        end
      end

      if (done) begin
        acc_nxt = '0;
        if (!(mark_done && skip_bom)) begin
          if (count_r != '1) begin
            count_nxt = count_r + u8sd_pkg::COUNT_WIDTH'(1);
          end
          result.valid      = 1'b1;
          result.code_point = cp;
          result.scalar_ok  = u8sd_pkg::is_scalar(cp);
          result.char_count = u8sd_pkg::reported_count(count_nxt);
          result.status     = u8sd_pkg::STATUS_OK;
        end
      end
    end

    if (!item.valid) begin
      result.valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r      <= '0;
      rem_r      <= 3'd0;
      count_r    <= '0;
      err_r      <= 1'b0;
      bom_pos_r  <= 2'd0;
      bom_cand_r <= 1'b1;
    end else if (advance) begin
      acc_r      <= acc_nxt;
      rem_r      <= rem_nxt;
      count_r    <= count_nxt;
      err_r      <= err_nxt;
      bom_pos_r  <= bom_pos_nxt;
      bom_cand_r <= bom_cand_nxt;
    end
  end

endmodule

// ===== rtl/u8sd_out_stage.sv =====
module u8sd_out_stage (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          item_valid,
  input  u8sd_pkg::result_t             result,
  output logic                          advance,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_kind,
  output logic [u8sd_pkg::CP_WIDTH-1:0] out_code_point,
  output logic                          out_scalar_ok,
  output logic [31:0]                   out_char_count,
  output logic                          out_status
);

  logic              valid_r, valid_nxt;
  u8sd_pkg::result_t data_r;
  logic              load;

  assign advance = item_valid && (!valid_r || !out_stall);
  assign load    = advance && result.valid;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= result;
    end
  end

  assign out_valid      = valid_r;
  assign out_kind       = data_r.kind;
  assign out_code_point = data_r.code_point;
  assign out_scalar_ok  = data_r.scalar_ok;
  assign out_char_count = data_r.char_count;
  assign out_status     = data_r.status;

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import u8sd_pkg::*;

  typedef struct {
    logic                kind;
    logic [CP_WIDTH-1:0] code_point;
    logic                scalar_ok;
    logic [31:0]         char_count;
    logic                status;
  } decoded_t;

  class utf8_scoreboard;
    logic                   skip_bom;
    logic [CP_WIDTH-1:0]    acc;
    logic [2:0]             remaining;
    logic [COUNT_WIDTH-1:0] count;
    logic                   error_seen;
    logic [1:0]             mark_pos;
    logic                   mark_possible;
    decoded_t               decoded_q[$];
    int                     failures;

    function new();
      skip_bom = 1'b1;
      failures = 0;
      clear_stream();
    endfunction

    function void clear_stream();
      acc = '0;
      remaining = '0;
      count = '0;
      error_seen = 1'b0;
      mark_pos = '0;
      mark_possible = 1'b1;
    endfunction

    function logic [31:0] reported();
      logic [63:0] wide;
      wide = 64'(count);
      return (wide > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : wide[31:0];
    endfunction

    function void decode_byte(input logic [7:0] b, input logic term);
      decoded_t            e;
      logic [7:0]          want;
      logic [2:0]          len;
      logic [6:0]          pay;
      logic                done;
      logic                mark_done;
      logic [CP_WIDTH-1:0] cp;
      done = 1'b0;
      mark_done = 1'b0;
      cp = '0;
      len = '0;
      pay = '0;
      if (term) begin
        e.kind = KIND_SUMMARY;
        e.code_point = '0;
        e.scalar_ok = 1'b0;
        e.char_count = reported();
        e.status = (error_seen || remaining != 0) ? STATUS_INVALID : STATUS_OK;
        decoded_q.push_back(e);
        clear_stream();
        return;
      end
      if (error_seen) return;
      if (mark_possible) begin
        case (mark_pos)
          2'd0:    want = BOM_BYTE0;
          2'd1:    want = BOM_BYTE1;
          default: want = BOM_BYTE2;
        endcase
        if (b == want) begin
          mark_pos++;
          if (mark_pos == 2'd3) begin
            mark_done = 1'b1;
            mark_possible = 1'b0;
          end
        end else begin
          mark_possible = 1'b0;
        end
      end
      if (remaining == 0) begin
        casez (b)
          8'b0???????: begin len = 3'd1; pay = b[6:0]; end
          8'b110?????: begin len = 3'd2; pay = {2'b00, b[4:0]}; end
          8'b1110????: begin len = 3'd3; pay = {3'b000, b[3:0]}; end
          8'b11110???: begin len = 3'd4; pay = {4'b0000, b[2:0]}; end
          8'b111110??: begin len = 3'd5; pay = {5'b00000, b[1:0]}; end
          8'b1111110?: begin len = 3'd6; pay = {6'b000000, b[0]}; end
          default:     len = 3'd0;
        endcase
        if (len == 0) begin
          error_seen = 1'b1;
          return;
        end
        if (len == 1) begin
          cp = CP_WIDTH'(pay);
          done = 1'b1;
        end else begin
          acc = CP_WIDTH'(pay);
          remaining = len - 3'd1;
        end
      end else begin
        acc = {acc[CP_WIDTH-7:0], b[5:0]};
        remaining--;
        if (remaining == 0) begin
          cp = acc;
          done = 1'b1;
        end
      end
      if (!done) return;
      acc = '0;
      if (mark_done && skip_bom) return;
      if (count != '1) count++;
      e.kind = KIND_CODE_POINT;
      e.code_point = cp;
      e.scalar_ok = (cp < SCALAR_LIMIT) && ((cp < SURROGATE_LOW) || (cp > SURROGATE_HIGH));
      e.char_count = reported();
      e.status = STATUS_OK;
      decoded_q.push_back(e);
    endfunction

    function void check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        failures++;
      end
    endfunction

    function void compare_word(input logic kind, input logic [CP_WIDTH-1:0] cp,
                               input logic ok, input logic [31:0] cnt, input logic st);
      decoded_t e;
      if (decoded_q.size() == 0) begin
        $display("%0t: unexpected word, kind %0h code point %0h count %0h status %0h",
                 $time, kind, cp, cnt, st);
        failures++;
        return;
      end
      e = decoded_q.pop_front();
      check_field("kind", 32'(e.kind), 32'(kind));
      check_field("code_point", 32'(e.code_point), 32'(cp));
      check_field("scalar_ok", 32'(e.scalar_ok), 32'(ok));
      check_field("char_count", e.char_count, cnt);
      check_field("status", 32'(e.status), 32'(st));
    endfunction
  endclass

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  logic [7:0]          in_data_byte;
  logic                in_is_terminator;
  logic                out_valid;
  logic                out_stall;
  logic                out_kind;
  logic [CP_WIDTH-1:0] out_code_point;
  logic                out_scalar_ok;
  logic [31:0]         out_char_count;
  logic                out_status;
  logic                cfg_valid;
  logic                cfg_ready;
  logic                cfg_data;

  utf8_scoreboard sb = new();
  int burst_left = 0;
  int hold_left = 0;
  int items_sent = 0;
  int stall_mode = 0;
  int mode_left = 0;

  utf8_stream_decoder dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_data_byte     (in_data_byte),
    .in_is_terminator (in_is_terminator),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_kind         (out_kind),
    .out_code_point   (out_code_point),
    .out_scalar_ok    (out_scalar_ok),
    .out_char_count   (out_char_count),
    .out_status       (out_status),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_data         (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      if (mode_left <= 0) begin
        stall_mode = $urandom_range(0, 2);
        mode_left = $urandom_range(20, 200);
      end
      mode_left--;
      case (stall_mode)
        0:       out_stall <= 1'b0;
        1:       out_stall <= ($urandom_range(0, 3) == 0);
        default: out_stall <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_stall == 1'b0)
      sb.compare_word(out_kind, out_code_point, out_scalar_ok, out_char_count, out_status);
  end

  task automatic send_word(input logic [7:0] b, input logic term);
    int gap;
    if (burst_left <= 0) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(0, 4);
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = $urandom_range(1, 60);
    end
    burst_left--;
    @(negedge clk);
    in_valid <= 1'b1;
    in_data_byte <= b;
    in_is_terminator <= term;
    do @(posedge clk); while (in_stall !== 1'b0);
    sb.decode_byte(b, term);
    items_sent++;
  endtask

  task automatic write_skip_bom(input logic v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    sb.skip_bom = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic pause_sender();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.decoded_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic send_string(input int n_chars);
    int             pick;
    int             form;
    int             n_cont;
    int             i;
    int             j;
    int             k;
    logic           cut;
    logic [30:0]    v;
    logic [7:0]     lead;
    logic [1:0]     hi;
    pick = $urandom_range(0, 9);
    if (pick < 3) begin
      send_word(BOM_BYTE0, 1'b0);
      send_word(BOM_BYTE1, 1'b0);
      send_word(BOM_BYTE2, 1'b0);
    end else if (pick == 3) begin
      send_word(BOM_BYTE0, 1'b0);
      if ($urandom_range(0, 1) == 1) send_word(BOM_BYTE1, 1'b0);
    end
    for (i = 0; i < n_chars; i++) begin
      if ($urandom_range(0, 99) < 8) begin
        send_word(8'($urandom_range(0, 255)), 1'b0);
        continue;
      end
      pick = $urandom_range(0, 9);
      form = (pick < 4) ? 1 : (pick < 6) ? 2 : (pick == 6) ? 3 :
             (pick == 7) ? 4 : (pick == 8) ? 5 : 6;
      v = 31'($urandom());
      if ($urandom_range(0, 7) == 0) begin
        case ($urandom_range(0, 5))
          0:       v = 31'h0000_D7FF;
          1:       v = 31'h0000_D800;
          2:       v = 31'h0000_DFFF;
          3:       v = 31'h0000_E000;
          4:       v = 31'h0010_FFFF;
          default: v = 31'h0011_0000;
        endcase
        if (form < 4) form = (v > 31'h0000_FFFF) ? 4 : 3;
      end
      if (form == 1) begin
        send_word({1'b0, v[6:0]}, 1'b0);
        continue;
      end
      lead = ~(8'hFF >> form) | (8'(v >> (6 * (form - 1))) & (8'hFF >> (form + 1)));
      cut = ($urandom_range(0, 24) == 0);
      n_cont = cut ? $urandom_range(0, form - 2) : form - 1;
      send_word(lead, 1'b0);
      for (j = 0; j < n_cont; j++) begin
        k = form - 2 - j;
        hi = ($urandom_range(0, 15) == 0) ? 2'($urandom_range(0, 3)) : 2'b10;
        send_word({hi, 6'(v >> (6 * k))}, 1'b0);
      end
      if (cut) begin
        send_word(8'($urandom_range(0, 255)), 1'b1);
        return;
      end
    end
    send_word(8'($urandom_range(0, 255)), 1'b1);
  endtask

  task automatic random_phase(input int budget);
    int stop;
    stop = items_sent + budget;
    while (items_sent < stop) send_string($urandom_range(0, 10));
  endtask

  // The receiver holds off while the sender keeps offering words without gaps.
  task automatic press_receiver();
    int i;
    hold_left = 80;
    burst_left = 64;
    for (i = 0; i < 24; i++) send_word(8'(8'h20 + i), 1'b0);
    send_word(8'h00, 1'b1);
  endtask

  initial begin
    logic [8:0] directed[$];
    int         i;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data_byte = '0;
    in_is_terminator = 1'b0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = 1'b0;
    directed = '{9'h0EF, 9'h0BB, 9'h0BF, 9'h000, 9'h07F,
                 9'h0FD, 9'h0BF, 9'h0BF, 9'h0BF, 9'h0BF, 9'h0BF, 9'h100,
                 9'h0F8, 9'h088, 9'h080, 9'h080, 9'h080, 9'h0ED, 9'h0A0, 9'h080, 9'h1FF,
                 9'h0E2, 9'h082, 9'h100,
                 9'h0FF, 9'h041, 9'h100,
                 9'h0FE, 9'h080, 9'h155};
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    write_skip_bom(1'b1);
    for (i = 0; i < directed.size(); i++) send_word(directed[i][7:0], directed[i][8]);
    pause_sender();
    write_skip_bom(1'b0);
    random_phase(175);
    press_receiver();
    pause_sender();
    write_skip_bom(1'b1);
    random_phase(175);
    pause_sender();
    write_skip_bom(1'b0);
    random_phase(175);
    pause_sender();
    write_skip_bom(1'b1);
    random_phase(175);
    pause_sender();
    if (sb.failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/u8sd_pkg.sv
rtl/u8sd_in_stage.sv
rtl/u8sd_core.sv
rtl/u8sd_out_stage.sv
rtl/utf8_stream_decoder.sv
tb/sv/testbench.sv
